>>> rtl/core/dmom_pkg.sv
`default_nettype none

package dmom_pkg;

   localparam int OUTCOME_BITS = 16;
   localparam int PROB_BITS    = 17;
   localparam int MAG_BITS     = OUTCOME_BITS;
   localparam int PROD_BITS    = MAG_BITS + PROB_BITS;
   localparam int XSQ_BITS     = 2 * MAG_BITS;
   localparam int SQ_BITS      = XSQ_BITS + PROB_BITS;
   localparam int SUM_BITS     = 42;
   localparam int SQSUM_BITS   = 56;
   localparam int VAR_BITS     = 55;
   localparam int FRAC_BITS    = 16;
   localparam int HI_BITS      = 20;
   localparam int MSQ_BITS     = SQSUM_BITS + 1;
   localparam int ROOT_BITS    = 28;
   localparam int REM_BITS     = ROOT_BITS + 1;
   localparam int RAD_BITS     = 2 * ROOT_BITS;
   localparam int CNT_BITS     = $clog2(ROOT_BITS);

   typedef struct packed {
      logic signed [OUTCOME_BITS-1:0] outcome;
      logic [PROB_BITS-1:0]           probability;
      logic                           last_pair;
   } req_type;

   typedef struct packed {
      logic signed [SUM_BITS-1:0] mean;
      logic [VAR_BITS-1:0]        variance;
      logic [ROOT_BITS-1:0]       std_dev;
      logic                       variance_negative;
   } rsp_type;

   typedef struct packed {
      logic accept;
      logic mag;
      logic mul;
      logic sum;
      logic sub;
      logic root_step;
      logic load;
   } cmd_type;

   typedef struct packed {
      logic root_last;
      logic out_busy;
   } sts_type;

endpackage

`default_nettype wire

>>> rtl/core/dmom_ctrl.sv
`default_nettype none

module dmom_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic             req_last,
   output logic                  req_stall,
   input  wire dmom_pkg::sts_type sts,
   output dmom_pkg::cmd_type     cmd
);
   import dmom_pkg::*;

   localparam logic [3:0] ST_ACCUM  = 4'd0;
   localparam logic [3:0] ST_DRAIN1 = 4'd1;
   localparam logic [3:0] ST_DRAIN2 = 4'd2;
   localparam logic [3:0] ST_MAG    = 4'd3;
   localparam logic [3:0] ST_MUL    = 4'd4;
   localparam logic [3:0] ST_SUM    = 4'd5;
   localparam logic [3:0] ST_SUB    = 4'd6;
   localparam logic [3:0] ST_ROOT   = 4'd7;
   localparam logic [3:0] ST_LOAD   = 4'd8;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   assign req_stall = (state_ff != ST_ACCUM);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_ACCUM: begin
            cmd.accept = req_valid;
            if (req_valid && req_last) begin
               state_in = ST_DRAIN1;
            end
         end
         ST_DRAIN1: state_in = ST_DRAIN2;
         ST_DRAIN2: state_in = ST_MAG;
         ST_MAG: begin
            cmd.mag  = 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum  = 1'b1;
            state_in = ST_SUB;
         end
         ST_SUB: begin
            cmd.sub  = 1'b1;
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            cmd.root_step = 1'b1;
            if (sts.root_last) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (!sts.out_busy) begin
               cmd.load = 1'b1;
               state_in = ST_ACCUM;
            end
         end
         default: state_in = ST_ACCUM;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_ACCUM;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/dmom_dp.sv
`default_nettype none

module dmom_dp (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire dmom_pkg::req_type req_data,
   input  wire dmom_pkg::cmd_type cmd,
   output dmom_pkg::sts_type      sts,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output dmom_pkg::rsp_type      rsp_data
);
   import dmom_pkg::*;

   // multiply pipeline
   logic                 s1_valid_ff;
   logic                 s1_neg_ff;
   logic [PROD_BITS-1:0] s1_prod_ff;
   logic [XSQ_BITS-1:0]  s1_xsq_ff;
   logic [PROB_BITS-1:0] s1_prob_ff;
   logic                 s2_valid_ff;
   logic                 s2_neg_ff;
   logic [PROD_BITS-1:0] s2_prod_ff;
   logic [SQ_BITS-1:0]   s2_sq_ff;

   logic [SUM_BITS-1:0]   ws_ff;
   logic [SUM_BITS-1:0]   ws_in;
   logic [SQSUM_BITS-1:0] wss_ff;
   logic [SQSUM_BITS-1:0] wss_in;

   logic [OUTCOME_BITS-1:0] xraw;
   logic [MAG_BITS-1:0]     xmag;

   // finishing
   logic [SUM_BITS-1:0]     mmag;
   logic [HI_BITS-1:0]      hi_ff;
   logic [FRAC_BITS-1:0]    lo_ff;
   logic                    big_ff;
   logic [2*HI_BITS-1:0]    hh_ff;
   logic [HI_BITS+FRAC_BITS-1:0] hl_ff;
   logic [2*FRAC_BITS-1:0]  ll_ff;
   logic [MSQ_BITS-1:0]     msq_ff;
   logic                    negative;
   logic [SQSUM_BITS-1:0]   diff;
   logic [VAR_BITS-1:0]     var_in;
   logic [VAR_BITS-1:0]     var_ff;
   logic                    neg_ff;

   // square root
   logic [RAD_BITS-1:0]     rad_ff;
   logic [REM_BITS-1:0]     rem_ff;
   logic [ROOT_BITS-1:0]    root_ff;
   logic [CNT_BITS-1:0]     cnt_ff;
   logic [REM_BITS+1:0]     trial_rem;
   logic [REM_BITS+1:0]     trial_sub;

   logic    rsp_valid_ff;
   rsp_type rsp_ff;

   assign xraw = req_data.outcome;
   assign xmag = xraw[OUTCOME_BITS-1] ? (~xraw + 1'b1) : xraw;

   always_ff @(posedge clock) begin
      s1_prod_ff <= PROD_BITS'(xmag) * PROD_BITS'(req_data.probability);
      s1_xsq_ff  <= XSQ_BITS'(xmag) * XSQ_BITS'(xmag);
      s1_prob_ff <= req_data.probability;
      s1_neg_ff  <= xraw[OUTCOME_BITS-1];
      s2_prod_ff <= s1_prod_ff;
      s2_sq_ff   <= SQ_BITS'(s1_xsq_ff) * SQ_BITS'(s1_prob_ff);
      s2_neg_ff  <= s1_neg_ff;
   end

   always_comb begin
      ws_in  = ws_ff;
      wss_in = wss_ff;
      if (cmd.load) begin
         ws_in  = '0;
         wss_in = '0;
      end else if (s2_valid_ff) begin
         if (s2_neg_ff) begin
            ws_in = ws_ff - SUM_BITS'(s2_prod_ff);
         end else begin
            ws_in = ws_ff + SUM_BITS'(s2_prod_ff);
         end
         wss_in = wss_ff + SQSUM_BITS'(s2_sq_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         ws_ff       <= '0;
         wss_ff      <= '0;
      end else begin
         s1_valid_ff <= cmd.accept;
         s2_valid_ff <= s1_valid_ff;
         ws_ff       <= ws_in;
         wss_ff      <= wss_in;
      end
   end

   assign mmag = ws_ff[SUM_BITS-1] ? (~ws_ff + 1'b1) : ws_ff;

   always_comb begin
      negative = big_ff || (msq_ff > {1'b0, wss_ff});
      diff     = wss_ff - msq_ff[SQSUM_BITS-1:0];
      if (negative) begin
         var_in = '0;
      end else if (diff[SQSUM_BITS-1]) begin
         var_in = '1;
      end else begin
         var_in = diff[VAR_BITS-1:0];
      end
   end

   assign trial_rem = {rem_ff, rad_ff[RAD_BITS-1 -: 2]};
   assign trial_sub = (REM_BITS+2)'({root_ff, 2'b01});

   always_ff @(posedge clock) begin
      if (cmd.mag) begin
         hi_ff  <= mmag[FRAC_BITS +: HI_BITS];
         lo_ff  <= mmag[FRAC_BITS-1:0];
         big_ff <= |mmag[SUM_BITS-1:FRAC_BITS+HI_BITS];
      end
      if (cmd.mul) begin
         hh_ff <= hi_ff * hi_ff;
         hl_ff <= hi_ff * lo_ff;
         ll_ff <= lo_ff * lo_ff;
      end
      if (cmd.sum) begin
         msq_ff <= MSQ_BITS'({hh_ff, {FRAC_BITS{1'b0}}})
                 + MSQ_BITS'({hl_ff, 1'b0})
                 + MSQ_BITS'(ll_ff[2*FRAC_BITS-1:FRAC_BITS]);
      end
      if (cmd.sub) begin
         var_ff  <= var_in;
         neg_ff  <= negative;
         rad_ff  <= RAD_BITS'(var_in);
         rem_ff  <= '0;
         root_ff <= '0;
         cnt_ff  <= '0;
      end else if (cmd.root_step) begin
         rad_ff <= {rad_ff[RAD_BITS-3:0], 2'b00};
         cnt_ff <= cnt_ff + 1'b1;
         if (trial_rem >= trial_sub) begin
            rem_ff  <= REM_BITS'(trial_rem - trial_sub);
            root_ff <= {root_ff[ROOT_BITS-2:0], 1'b1};
         end else begin
            rem_ff  <= REM_BITS'(trial_rem);
            root_ff <= {root_ff[ROOT_BITS-2:0], 1'b0};
         end
      end
   end

   assign sts.root_last = (cnt_ff == CNT_BITS'(ROOT_BITS - 1));
   assign sts.out_busy  = rsp_valid_ff && rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_ff.mean              <= ws_ff;
         rsp_ff.variance          <= var_ff;
         rsp_ff.std_dev           <= root_ff;
         rsp_ff.variance_negative <= neg_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

>>> rtl/core/discrete_distribution_moments.sv
`default_nettype none

// Mean, variance and standard deviation of a discrete distribution. Each request
// carries one (outcome, probability) pair and is accepted without stall while the
// block collects a distribution; the pair marked last closes it, and the block
// then stalls requests while it drains the multiply pipeline, forms the mean
// squared (magnitude, multiply, sum) and subtracts it, runs the one-bit-per-cycle
// square root and loads the result register, which waits while the previous
// result is still stalled. Results: mean Q.16 signed, variance Q.16 clamped at zero
// with a flag when it came out negative, std_dev Q.8.
module discrete_distribution_moments (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire dmom_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output dmom_pkg::rsp_type      rsp_data
);
   import dmom_pkg::*;

   cmd_type cmd;
   sts_type sts;

   dmom_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_data.last_pair),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   dmom_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
